// ===== hdl/frd_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// frd_pkg
// Shared types and constants for the frame route dispatcher.
// ---------------------------------------------------------------------------
package frd_pkg;

  localparam int ROUTE_ENTRIES = 8;
  localparam int SEEN_ENTRIES  = 8;
  localparam int HDR_BYTES     = 3;

  localparam int RT_IW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int SN_IW = (SEEN_ENTRIES > 1) ? $clog2(SEEN_ENTRIES) : 1;

  localparam int CFG_IW = 1;

  typedef enum logic [CFG_IW-1:0] {
    CFG_EXPECTED_HEAD = 1'd0,
    CFG_MAX_PAYLOAD   = 1'd1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_DELIVERED    = 4'd0,
    ST_NEW          = 4'd1,
    ST_OVERWRITTEN  = 4'd2,
    ST_FULL         = 4'd3,
    ST_NULL         = 4'd4,
    ST_SHORT        = 4'd5,
    ST_BAD_HEAD     = 4'd6,
    ST_TRUNCATED    = 4'd7,
    ST_UNREGISTERED = 4'd8
  } status_t;

  typedef struct packed {
    logic       upd;
    logic [7:0] tag;
  } rt_cmd_t;

  typedef struct packed {
    logic             hit;
    logic [RT_IW-1:0] hit_idx;
    logic [7:0]       hit_tag;
    logic             free_ok;
    logic [RT_IW-1:0] free_idx;
  } rt_resp_t;

endpackage
`default_nettype wire

// ===== hdl/frame_route_dispatcher.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// frame_route_dispatcher
// Route registration and frame header dispatch against a small route table.
// ---------------------------------------------------------------------------
// One word is taken per clock while in_ready is high. Each word passes an
// input register, which feeds the header checks and the parallel table
// compares, and then the result register, which takes their outcome. The
// table updates land on the same edge that loads the result register, so the
// next word already sees them. A stalled result register holds the input
// register; in_ready drops only when both hold a word and out_ready is low.
module frame_route_dispatcher
  import frd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [7:0]        cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_mode,
  input  wire logic [7:0]        in_head_byte,
  input  wire logic [7:0]        in_func_code,
  input  wire logic [7:0]        in_length_byte,
  input  wire logic [7:0]        in_frame_size,
  input  wire logic [7:0]        in_handler_tag,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [3:0]             out_status,
  output logic [2:0]             out_route_index,
  output logic [7:0]             out_dest_tag,
  output logic [7:0]             out_body_len,
  output logic                   out_report_unknown
);

  logic [7:0] expected_head_r;
  logic [7:0] max_body_len_r;

  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_mode_r;
  logic [7:0] s1_head_r, s1_code_r, s1_len_r, s1_size_r, s1_tag_r;

  logic       out_valid_r, out_valid_nxt;
  status_t    out_status_r, status_nxt;
  logic [2:0] out_idx_r, idx_nxt;
  logic [7:0] out_dtag_r, dtag_nxt;
  logic [7:0] out_plen_r, plen_nxt;
  logic       out_report_r, report_nxt;

  logic       in_acc;
  logic       s1_adv;
  logic [7:0] plen_clamp;
  logic       rec_en;
  logic       seen;
  rt_cmd_t    rt_cmd;
  rt_resp_t   rt_resp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_head_r <= 8'd0;
      max_body_len_r  <= 8'd32;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_EXPECTED_HEAD: expected_head_r <= cfg_wdata;
        CFG_MAX_PAYLOAD:   max_body_len_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r <= in_mode;
      s1_head_r <= in_head_byte;
      s1_code_r <= in_func_code;
      s1_len_r  <= in_length_byte;
      s1_size_r <= in_frame_size;
      s1_tag_r  <= in_handler_tag;
    end
  end

  frd_route_table u_route (
    .clk   (clk),
    .rst_n (rst_n),
    .code  (s1_code_r),
    .cmd   (rt_cmd),
    .resp  (rt_resp)
  );

  frd_seen_table u_seen (
    .clk    (clk),
    .rst_n  (rst_n),
    .code   (s1_code_r),
    .rec_en (rec_en),
    .seen   (seen)
  );

  assign plen_clamp = (s1_len_r > max_body_len_r) ? max_body_len_r : s1_len_r;

  always_comb begin
    status_nxt = ST_NULL;
    idx_nxt    = 3'd0;
    dtag_nxt   = 8'd0;
    plen_nxt   = 8'd0;
    report_nxt = 1'b0;
    rec_en     = 1'b0;
    rt_cmd.upd = 1'b0;
    rt_cmd.tag = s1_tag_r;
    if (!s1_mode_r) begin
      if (s1_tag_r == 8'd0) begin
        status_nxt = ST_NULL;
      end else begin
        rt_cmd.upd = s1_adv;
        if (rt_resp.hit) begin
          status_nxt = ST_OVERWRITTEN;
          idx_nxt    = 3'(rt_resp.hit_idx);
        end else if (rt_resp.free_ok) begin
          status_nxt = ST_NEW;
          idx_nxt    = 3'(rt_resp.free_idx);
        end else begin
          status_nxt = ST_FULL;
        end
      end
    end else if (s1_size_r < 8'(HDR_BYTES)) begin
      status_nxt = ST_SHORT;
    end else if (s1_head_r != expected_head_r) begin
      status_nxt = ST_BAD_HEAD;
    end else begin
      plen_nxt = plen_clamp;
      if ({1'b0, s1_size_r} < (9'(HDR_BYTES) + {1'b0, plen_clamp})) begin
        status_nxt = ST_TRUNCATED;
      end else if (rt_resp.hit) begin
        status_nxt = ST_DELIVERED;
        idx_nxt    = 3'(rt_resp.hit_idx);
        dtag_nxt   = rt_resp.hit_tag;
      end else begin
        status_nxt = ST_UNREGISTERED;
        report_nxt = !seen;
        rec_en     = s1_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r <= status_nxt;
      out_idx_r    <= idx_nxt;
      out_dtag_r   <= dtag_nxt;
      out_plen_r   <= plen_nxt;
      out_report_r <= report_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_route_index    = out_idx_r;
  assign out_dest_tag       = out_dtag_r;
  assign out_body_len       = out_plen_r;
  assign out_report_unknown = out_report_r;

  a_stall_both_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r))
    else $error("input stalled while a stage is free");

  a_report_unreg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_report_r) |-> (out_status_r == ST_UNREGISTERED))
    else $error("report flag on a non-unregistered result");

  a_tag_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_status_r == ST_DELIVERED) == (out_dtag_r != 8'd0)))
    else $error("dest tag does not match delivered status");

  a_plen_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_mode_r) |-> (plen_nxt <= max_body_len_r))
    else $error("payload length above the clamp");

endmodule
`default_nettype wire

// ===== hdl/frd_route_table.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// frd_route_table
// Route slots with parallel code match, lowest-free search and one update.
// ---------------------------------------------------------------------------
module frd_route_table
  import frd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] code,
  input  wire rt_cmd_t    cmd,
  output rt_resp_t        resp
);

  logic [ROUTE_ENTRIES-1:0] valid_r;
  logic [7:0]               code_r [ROUTE_ENTRIES];
  logic [7:0]               tag_r  [ROUTE_ENTRIES];

  always_comb begin
    resp = '0;
    for (int i = ROUTE_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (code_r[i] == code)) begin
        resp.hit     = 1'b1;
        resp.hit_idx = RT_IW'(i);
      end
      if (!valid_r[i]) begin
        resp.free_ok  = 1'b1;
        resp.free_idx = RT_IW'(i);
      end
    end
    resp.hit_tag = tag_r[resp.hit_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.upd && !resp.hit && resp.free_ok) begin
      valid_r[resp.free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      if (resp.hit) begin
        tag_r[resp.hit_idx] <= cmd.tag;
      end else if (resp.free_ok) begin
        code_r[resp.free_idx] <= code;
        tag_r[resp.free_idx]  <= cmd.tag;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/frd_seen_table.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// frd_seen_table
// Record of unregistered codes already reported, filled lowest slot first.
// ---------------------------------------------------------------------------
module frd_seen_table
  import frd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] code,
  input  wire logic       rec_en,
  output logic            seen
);

  logic [SEEN_ENTRIES-1:0] valid_r;
  logic [7:0]              code_r [SEEN_ENTRIES];
  logic                    free_ok;
  logic [SN_IW-1:0]        free_idx;

  always_comb begin
    seen     = 1'b0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = SEEN_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (code_r[i] == code)) begin
        seen = 1'b1;
      end
      if (!valid_r[i]) begin
        free_ok  = 1'b1;
        free_idx = SN_IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (rec_en && !seen && free_ok) begin
      valid_r[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_en && !seen && free_ok) begin
      code_r[free_idx] <= code;
    end
  end

endmodule
`default_nettype wire
